// ===== hw/rtl/scara_inverse_kinematics_macros.svh =====
// Assertion macros shared by the SCARA inverse kinematics modules.
// They expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef SCARA_INVERSE_KINEMATICS_MACROS_SVH
`define SCARA_INVERSE_KINEMATICS_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds in the same cycle as the antecedent.
`define SCARA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scara_ik: same-cycle check failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define SCARA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scara_ik: next-cycle check failed");
`else
`define SCARA_ASSERT_IMPL(label, ante, cons)
`define SCARA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/scara_ik_pkg.sv =====
package scara_ik_pkg;

    // Register reset values.
    localparam logic [9:0]  RST_UPPER_ARM   = 10'd205;
    localparam logic [9:0]  RST_FOREARM     = 10'd90;
    localparam logic [11:0] RST_BASE_HEIGHT = 12'd120;

    // Pipeline depths of the fixed parts of the datapath.
    localparam int FRONT_STAGES    = 5;
    localparam int SQRT_STAGES     = 32;
    localparam int CORDIC_OVERHEAD = 5;

    // Register map, one word per register.
    typedef enum logic [1:0] {
        REG_UPPER_ARM   = 2'd0,
        REG_FOREARM     = 2'd1,
        REG_BASE_HEIGHT = 2'd2
    } reg_idx_t;

    // Values that travel alongside the square root pipeline.
    typedef struct packed {
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic signed [23:0] num;
        logic signed [43:0] xa;
        logic signed [15:0] travel;
        logic               out_of_reach;
    } side_t;

    // Unsigned long division by shift and subtract, used only for constants.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) in units of 2^-60 rad by a truncated integer series.
    function automatic logic [63:0] atan_recip(input logic [63:0] m);
        logic [63:0] m2;
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] term;
        m2  = m * m;
        p   = udiv64(64'd1 << 60, m);
        sum = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (p != 64'd0)
            begin
                term = udiv64(p, 64'(2 * k + 1));
                if (k[0])
                    sum = sum - term;
                else
                    sum = sum + term;
                p = udiv64(p, m2);
            end
        end
        return sum;
    endfunction

    // Angle of CORDIC stage i; stage 0 is pi/4 by Machin's formula.
    function automatic logic [63:0] atan_entry(input int i);
        if (i == 0)
            return (atan_recip(64'd5) << 2) - atan_recip(64'd239);
        return atan_recip(64'd1 << i);
    endfunction

endpackage

// ===== hw/rtl/scara_ik_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module scara_ik_isqrt
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [63:0]          in_rad,
    input  scara_ik_pkg::side_t  in_side,
    output logic                 out_valid,
    output logic [31:0]          out_root,
    output scara_ik_pkg::side_t  out_side
);

    localparam int N = scara_ik_pkg::SQRT_STAGES;

    logic [63:0]         rem_reg  [0:N-1];
    logic [63:0]         root_reg [0:N-1];
    scara_ik_pkg::side_t side_reg [0:N-1];
    logic [N-1:0]        valid_reg;

    // Valid bits move one stage per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[N-2:0], in_valid};
    end

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0]         rem_in;
        logic [63:0]         root_in;
        logic [63:0]         trial;
        scara_ik_pkg::side_t side_in;

        if (k == 0)
        begin : g_first
            assign rem_in  = in_rad;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = root_in + BIT;

        // Take the bit when the trial value still fits in the remainder.
        always_ff @(posedge clk)
        begin
            if (rem_in >= trial)
            begin
                rem_reg[k]  <= rem_in - trial;
                root_reg[k] <= (root_in >> 1) + BIT;
            end
            else
            begin
                rem_reg[k]  <= rem_in;
                root_reg[k] <= root_in >> 1;
            end
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1][31:0];
    assign out_side  = side_reg[N-1];

endmodule

// ===== hw/rtl/scara_ik_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(in_y, in_x), rounded to FRAC fraction bits.
module scara_ik_cordic
#(
    parameter int STAGES = 18,
    parameter int FRAC   = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic signed [63:0]       in_y,
    input  logic signed [63:0]       in_x,
    output logic                     out_valid,
    output logic signed [FRAC+2:0]   out_angle
);

    localparam int              ANG_W = FRAC + 3;
    localparam int              SH    = 60 - FRAC;
    localparam logic [63:0]     HALF  = 64'd1 << (SH - 1);
    localparam logic [63:0]     PI_U  = scara_ik_pkg::atan_entry(0) << 2;
    localparam logic signed [63:0] PI = $signed(PI_U);

    // Quadrant correction: a point with negative x is turned by pi.
    logic              pre_valid_reg;
    logic [63:0]       pre_ux_reg;
    logic [63:0]       pre_uy_reg;
    logic              pre_yneg_reg;
    logic signed [63:0] pre_base_reg;
    logic              pre_zero_reg;

    logic              xneg;
    logic              yneg_next;
    logic signed [63:0] base_next;

    always_comb
    begin
        xneg      = in_x < 0;
        yneg_next = xneg ? (in_y > 0) : (in_y < 0);
        if (!xneg)
            base_next = '0;
        else if (in_y >= 0)
            base_next = PI;
        else
            base_next = -PI;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else
            pre_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pre_ux_reg   <= xneg ? $unsigned(-in_x) : $unsigned(in_x);
        pre_uy_reg   <= (in_y < 0) ? $unsigned(-in_y) : $unsigned(in_y);
        pre_yneg_reg <= yneg_next;
        pre_base_reg <= base_next;
        pre_zero_reg <= (in_x == 0) && (in_y == 0);
    end

    // Normalisation, first half: shifts of 32, 16 and 8.
    logic              n1_valid_reg;
    logic [63:0]       n1_mx_reg;
    logic [63:0]       n1_ux_reg;
    logic [63:0]       n1_uy_reg;
    logic              n1_yneg_reg;
    logic signed [63:0] n1_base_reg;
    logic              n1_zero_reg;

    logic [63:0] mx_a;
    logic [63:0] ux_a;
    logic [63:0] uy_a;

    always_comb
    begin
        mx_a = (pre_ux_reg > pre_uy_reg) ? pre_ux_reg : pre_uy_reg;
        ux_a = pre_ux_reg;
        uy_a = pre_uy_reg;
        for (int j = 0; j < 3; j++)
        begin
            if ((mx_a >> (60 - (32 >> j))) == 64'd0)
            begin
                mx_a = mx_a << (32 >> j);
                ux_a = ux_a << (32 >> j);
                uy_a = uy_a << (32 >> j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n1_valid_reg <= 1'b0;
        else
            n1_valid_reg <= pre_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        n1_mx_reg   <= mx_a;
        n1_ux_reg   <= ux_a;
        n1_uy_reg   <= uy_a;
        n1_yneg_reg <= pre_yneg_reg;
        n1_base_reg <= pre_base_reg;
        n1_zero_reg <= pre_zero_reg;
    end

    // Normalisation, second half: shifts of 4, 2 and 1, then the signed start vector.
    logic [63:0] mx_b;
    logic [63:0] ux_b;
    logic [63:0] uy_b;

    always_comb
    begin
        mx_b = n1_mx_reg;
        ux_b = n1_ux_reg;
        uy_b = n1_uy_reg;
        for (int j = 0; j < 3; j++)
        begin
            if ((mx_b >> (60 - (4 >> j))) == 64'd0)
            begin
                mx_b = mx_b << (4 >> j);
                ux_b = ux_b << (4 >> j);
                uy_b = uy_b << (4 >> j);
            end
        end
    end

    logic signed [63:0] cx_reg [0:STAGES];
    logic signed [63:0] cy_reg [0:STAGES];
    logic signed [63:0] cz_reg [0:STAGES];
    logic [STAGES:0]    cv_reg;
    logic [STAGES:0]    czero_reg;

    always_ff @(posedge clk)
    begin
        cx_reg[0]    <= $signed(ux_b);
        cy_reg[0]    <= n1_yneg_reg ? -$signed(uy_b) : $signed(uy_b);
        cz_reg[0]    <= n1_base_reg;
        czero_reg    <= {czero_reg[STAGES-1:0], n1_zero_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg <= '0;
        else
            cv_reg <= {cv_reg[STAGES-1:0], n1_valid_reg};
    end

    // Rotation stages: each turns the vector towards the x axis.
    for (genvar i = 0; i < STAGES; i++)
    begin : g_rot
        localparam logic [63:0]        ANG_U = scara_ik_pkg::atan_entry(i);
        localparam logic signed [63:0] ANG   = $signed(ANG_U);

        always_ff @(posedge clk)
        begin
            if (cy_reg[i] >= 0)
            begin
                cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] + ANG;
            end
            else
            begin
                cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                cz_reg[i+1] <= cz_reg[i] - ANG;
            end
        end
    end

    // Rounding, first half: magnitude and sign.
    logic        ra_valid_reg;
    logic        ra_neg_reg;
    logic [63:0] ra_mag_reg;
    logic        ra_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ra_valid_reg <= 1'b0;
        else
            ra_valid_reg <= cv_reg[STAGES];
    end

    always_ff @(posedge clk)
    begin
        ra_neg_reg  <= cz_reg[STAGES] < 0;
        ra_mag_reg  <= (cz_reg[STAGES] < 0) ? $unsigned(-cz_reg[STAGES])
                                            : $unsigned(cz_reg[STAGES]);
        ra_zero_reg <= czero_reg[STAGES];
    end

    // Rounding, second half: halves go away from zero.
    logic                    out_valid_reg;
    logic signed [ANG_W-1:0] out_angle_reg;
    logic [63:0]             rnd_full;
    logic signed [ANG_W-1:0] rnd_mag;
    logic signed [ANG_W-1:0] out_angle_next;

    always_comb
    begin
        rnd_full = (ra_mag_reg + HALF) >> SH;
        rnd_mag  = $signed(rnd_full[ANG_W-1:0]);
        if (ra_zero_reg)
            out_angle_next = '0;
        else if (ra_neg_reg)
            out_angle_next = -rnd_mag;
        else
            out_angle_next = rnd_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= ra_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        out_angle_reg <= out_angle_next;
    end

    assign out_valid = out_valid_reg;
    assign out_angle = out_angle_reg;

endmodule

// ===== hw/rtl/scara_inverse_kinematics.sv =====
// SCARA inverse kinematics: a target point (x, y, z in hundredths of a metre) is taken with
// start while busy is low, and its joint values appear on the result ports for exactly one
// cycle, marked by done. One target can be taken in every cycle while busy is low; the
// pipeline depth is set by the 32-stage square root and the CORDIC arctangent chain, three
// of which run side by side. The receiver cannot hold results off, so every done pulse must
// be taken. busy is high only during reset and until its register is cleared once reset ends.
// A point out of reach, or a zero link length, raises out_of_reach with both angles zero;
// vertical_travel is always given. Link lengths and base height may be written through the
// APB port only while no target is in flight.
`include "scara_inverse_kinematics_macros.svh"

module scara_inverse_kinematics
#(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STAGES   = 18
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [14:0] target_x,
    input  logic signed [14:0] target_y,
    input  logic signed [14:0] target_z,
    output logic               done,
    output logic signed [19:0] shoulder_angle,
    output logic [17:0]        elbow_angle,
    output logic signed [15:0] vertical_travel,
    output logic               out_of_reach
);

    localparam int ANG_W    = ANGLE_FRAC_BITS + 3;
    localparam int DIFF_W   = ANG_W + 1;
    localparam int SIDE_DLY = CORDIC_STAGES + scara_ik_pkg::CORDIC_OVERHEAD;
    localparam int LATENCY  = scara_ik_pkg::FRONT_STAGES + scara_ik_pkg::SQRT_STAGES
                              + 1 + SIDE_DLY + 1;

    // Configuration registers.
    logic [9:0]  upper_arm_length_reg;
    logic [9:0]  forearm_length_reg;
    logic [11:0] base_height_reg;
    scara_ik_pkg::reg_idx_t reg_idx;
    logic cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = scara_ik_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_arm_length_reg <= scara_ik_pkg::RST_UPPER_ARM;
            forearm_length_reg   <= scara_ik_pkg::RST_FOREARM;
            base_height_reg      <= scara_ik_pkg::RST_BASE_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                scara_ik_pkg::REG_UPPER_ARM:   upper_arm_length_reg <= pwdata[9:0];
                scara_ik_pkg::REG_FOREARM:     forearm_length_reg   <= pwdata[9:0];
                scara_ik_pkg::REG_BASE_HEIGHT: base_height_reg      <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            scara_ik_pkg::REG_UPPER_ARM:   prdata = {22'd0, upper_arm_length_reg};
            scara_ik_pkg::REG_FOREARM:     prdata = {22'd0, forearm_length_reg};
            scara_ik_pkg::REG_BASE_HEIGHT: prdata = {20'd0, base_height_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // Busy is held through reset and is cleared by this register once reset is released.
    logic busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy = busy_reg;

    // Stage 1: input beat register.
    logic               s1_valid_reg;
    logic signed [14:0] s1_x_reg;
    logic signed [14:0] s1_y_reg;
    logic signed [14:0] s1_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start & ~busy_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg <= target_x;
        s1_y_reg <= target_y;
        s1_z_reg <= target_z;
    end

    // Stage 2: squares, link product and vertical travel.
    logic               s2_valid_reg;
    logic [28:0]        s2_sqx_reg;
    logic [28:0]        s2_sqy_reg;
    logic [19:0]        s2_sqa1_reg;
    logic [19:0]        s2_sqa2_reg;
    logic [20:0]        s2_den_reg;
    logic signed [14:0] s2_x_reg;
    logic signed [14:0] s2_y_reg;
    logic signed [15:0] s2_travel_reg;
    logic [19:0]        prod12;

    assign prod12 = {10'd0, upper_arm_length_reg} * {10'd0, forearm_length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_sqx_reg    <= 29'(30'(s1_x_reg) * 30'(s1_x_reg));
        s2_sqy_reg    <= 29'(30'(s1_y_reg) * 30'(s1_y_reg));
        s2_sqa1_reg   <= {10'd0, upper_arm_length_reg} * {10'd0, upper_arm_length_reg};
        s2_sqa2_reg   <= {10'd0, forearm_length_reg} * {10'd0, forearm_length_reg};
        s2_den_reg    <= {prod12, 1'b0};
        s2_x_reg      <= s1_x_reg;
        s2_y_reg      <= s1_y_reg;
        s2_travel_reg <= 16'(s1_z_reg) - $signed({4'd0, base_height_reg});
    end

    // Stage 3: cosine numerator and reach test.
    logic               s3_valid_reg;
    logic signed [30:0] s3_num_reg;
    logic [20:0]        s3_den_reg;
    logic               s3_flag_reg;
    logic signed [14:0] s3_x_reg;
    logic signed [14:0] s3_y_reg;
    logic signed [15:0] s3_travel_reg;
    logic signed [30:0] num_next;
    logic signed [30:0] den_wide;
    logic               flag_next;

    always_comb
    begin
        num_next  = $signed({2'd0, s2_sqx_reg}) + $signed({2'd0, s2_sqy_reg})
                    - $signed({11'd0, s2_sqa1_reg}) - $signed({11'd0, s2_sqa2_reg});
        den_wide  = $signed({10'd0, s2_den_reg});
        flag_next = (s2_den_reg == 21'd0) || (num_next > den_wide) || (num_next < -den_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_num_reg    <= num_next;
        s3_den_reg    <= s2_den_reg;
        s3_flag_reg   <= flag_next;
        s3_x_reg      <= s2_x_reg;
        s3_y_reg      <= s2_y_reg;
        s3_travel_reg <= s2_travel_reg;
    end

    // Stage 4: squares of numerator and denominator, terms of the second arctangent.
    logic               s4_valid_reg;
    logic [41:0]        s4_num2_reg;
    logic [41:0]        s4_den2_reg;
    logic [30:0]        s4_a1den_reg;
    logic signed [34:0] s4_a2num_reg;
    logic signed [23:0] s4_num_reg;
    logic               s4_flag_reg;
    logic signed [14:0] s4_x_reg;
    logic signed [14:0] s4_y_reg;
    logic signed [15:0] s4_travel_reg;
    logic signed [23:0] num_t;

    assign num_t = s3_num_reg[23:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_num2_reg   <= 42'(48'(num_t) * 48'(num_t));
        s4_den2_reg   <= {21'd0, s3_den_reg} * {21'd0, s3_den_reg};
        s4_a1den_reg  <= {21'd0, upper_arm_length_reg} * {10'd0, s3_den_reg};
        s4_a2num_reg  <= $signed({25'd0, forearm_length_reg}) * 35'(num_t);
        s4_num_reg    <= num_t;
        s4_flag_reg   <= s3_flag_reg;
        s4_x_reg      <= s3_x_reg;
        s4_y_reg      <= s3_y_reg;
        s4_travel_reg <= s3_travel_reg;
    end

    // Stage 5: radicand and the x term of the second arctangent.
    logic                s5_valid_reg;
    logic [63:0]         s5_rad_reg;
    scara_ik_pkg::side_t s5_side_reg;
    logic [41:0]         diff;
    logic signed [33:0]  xsum;
    scara_ik_pkg::side_t side_next;

    always_comb
    begin
        diff                   = s4_den2_reg - s4_num2_reg;
        xsum                   = 34'($signed({1'b0, s4_a1den_reg})) + 34'(s4_a2num_reg);
        side_next.x            = s4_x_reg;
        side_next.y            = s4_y_reg;
        side_next.num          = s4_num_reg;
        side_next.xa           = $signed({xsum, 10'd0});
        side_next.travel       = s4_travel_reg;
        side_next.out_of_reach = s4_flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s5_rad_reg  <= {2'd0, diff, 20'd0};
        s5_side_reg <= side_next;
    end

    // Square root of the scaled sine term.
    logic                sq_valid;
    logic [31:0]         sq_root;
    scara_ik_pkg::side_t sq_side;

    scara_ik_isqrt u_isqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .in_rad    (s5_rad_reg),
        .in_side   (s5_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Stage 6: y term of the second arctangent.
    logic                t6_valid_reg;
    logic [31:0]         t6_root_reg;
    logic [41:0]         t6_ya_reg;
    scara_ik_pkg::side_t t6_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t6_valid_reg <= 1'b0;
        else
            t6_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        t6_root_reg <= sq_root;
        t6_ya_reg   <= {32'd0, forearm_length_reg} * {10'd0, sq_root};
        t6_side_reg <= sq_side;
    end

    // Three arctangents side by side.
    logic                    c0_valid;
    logic signed [ANG_W-1:0] c0_angle;
    logic signed [ANG_W-1:0] c1_angle;
    logic signed [ANG_W-1:0] c2_angle;

    scara_ik_cordic #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_cordic_target
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t6_valid_reg),
        .in_y      (64'(t6_side_reg.y)),
        .in_x      (64'(t6_side_reg.x)),
        .out_valid (c0_valid),
        .out_angle (c0_angle)
    );

    scara_ik_cordic #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_cordic_elbow
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t6_valid_reg),
        .in_y      ($signed({32'd0, t6_root_reg})),
        .in_x      (64'($signed({t6_side_reg.num, 10'd0}))),
        .out_valid (),
        .out_angle (c1_angle)
    );

    scara_ik_cordic #(.STAGES(CORDIC_STAGES), .FRAC(ANGLE_FRAC_BITS)) u_cordic_offset
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t6_valid_reg),
        .in_y      ($signed({22'd0, t6_ya_reg})),
        .in_x      (64'(t6_side_reg.xa)),
        .out_valid (),
        .out_angle (c2_angle)
    );

    // Travel and reach flag wait alongside the arctangents.
    logic signed [15:0]  dly_travel_reg [0:SIDE_DLY-1];
    logic [SIDE_DLY-1:0] dly_flag_reg;

    always_ff @(posedge clk)
    begin
        dly_travel_reg[0] <= t6_side_reg.travel;
        for (int k = 1; k < SIDE_DLY; k++)
        begin
            dly_travel_reg[k] <= dly_travel_reg[k-1];
        end
        dly_flag_reg <= {dly_flag_reg[SIDE_DLY-2:0], t6_side_reg.out_of_reach};
    end

    // Output stage: shoulder angle is the difference of two arctangents.
    logic                     done_reg;
    logic signed [19:0]       shoulder_angle_reg;
    logic [17:0]              elbow_angle_reg;
    logic signed [15:0]       vertical_travel_reg;
    logic                     out_of_reach_reg;
    logic signed [DIFF_W-1:0] q1;
    logic                     flag_out;

    assign q1       = DIFF_W'(c0_angle) - DIFF_W'(c2_angle);
    assign flag_out = dly_flag_reg[SIDE_DLY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= c0_valid;
    end

    always_ff @(posedge clk)
    begin
        shoulder_angle_reg  <= flag_out ? 20'sd0 : 20'(q1);
        elbow_angle_reg     <= flag_out ? 18'd0 : 18'(c1_angle);
        vertical_travel_reg <= dly_travel_reg[SIDE_DLY-1];
        out_of_reach_reg    <= flag_out;
    end

    assign done            = done_reg;
    assign shoulder_angle  = shoulder_angle_reg;
    assign elbow_angle     = elbow_angle_reg;
    assign vertical_travel = vertical_travel_reg;
    assign out_of_reach    = out_of_reach_reg;

    // An unreachable point never shows a non-zero angle.
    `SCARA_ASSERT_IMPL(a_reach_zero, done && out_of_reach, shoulder_angle == 20'sd0 && elbow_angle == 18'd0)
    // Every result comes from a beat taken earlier, and every beat gives one.
    `SCARA_ASSERT_IMPL(a_done_has_beat, done, $past(start && !busy, LATENCY))
    `SCARA_ASSERT_IMPL(a_beat_gives_done, $past(start && !busy, LATENCY), done)
    // Once the pipeline is open it stays open.
    `SCARA_ASSERT_NEXT(a_busy_stays_low, !busy, !busy)

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scara_ik_pkg::*;

    localparam int ANGLE_BITS  = 16;
    localparam int STAGES      = 18;
    localparam int LATENCY     = 44 + STAGES;
    localparam int WATCH_LIMIT = 4000;
    localparam int PHASE_ITEMS = 173;

    typedef struct packed {
        logic signed [19:0] shoulder;
        logic [17:0]        elbow;
        logic signed [15:0] travel;
        logic               reach_fault;
    } joints_t;

    typedef struct {
        int      x;
        int      y;
        int      z;
        bit      typed;
        joints_t known;
    } target_row_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic signed [14:0] target_x;
    logic signed [14:0] target_y;
    logic signed [14:0] target_z;
    logic               done;
    logic signed [19:0] shoulder_angle;
    logic [17:0]        elbow_angle;
    logic signed [15:0] vertical_travel;
    logic               out_of_reach;

    // Shadow copy of the arm geometry.
    int unsigned link_a1;
    int unsigned link_a2;
    int unsigned base_z;

    longint unsigned arctan_q60 [32];
    joints_t         pending_joints [$];
    int              mismatches;
    int              idle_cycles;

    scara_inverse_kinematics uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .start           (start),
        .busy            (busy),
        .target_x        (target_x),
        .target_y        (target_y),
        .target_z        (target_z),
        .done            (done),
        .shoulder_angle  (shoulder_angle),
        .elbow_angle     (elbow_angle),
        .vertical_travel (vertical_travel),
        .out_of_reach    (out_of_reach)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Arctangent of 1/m in units of 2^-60 rad, by an alternating series.
    function automatic longint unsigned inverse_arctan(longint unsigned m);
        longint unsigned m2;
        longint unsigned p;
        longint unsigned sum;
        longint unsigned k;
        m2  = m * m;
        p   = (64'd1 << 60) / m;
        sum = 0;
        k   = 0;
        while (p != 0)
        begin
            if (k[0])
                sum = sum - p / (2 * k + 1);
            else
                sum = sum + p / (2 * k + 1);
            p = p / m2;
            k++;
        end
        return sum;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Vectoring CORDIC arctangent, result in units of 2^-60 rad.
    function automatic longint vector_angle(longint yv, longint xv);
        longint          half_turn;
        longint          base;
        longint          cx;
        longint          cy;
        longint          acc;
        longint          xs;
        longint          ys;
        longint unsigned ux;
        longint unsigned uy;
        longint unsigned mx;
        bit              yneg;
        half_turn = longint'(4 * arctan_q60[0]);
        base      = 0;
        acc       = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            xv   = -xv;
            yv   = -yv;
            base = (yv <= 0) ? half_turn : -half_turn;
        end
        yneg = yv < 0;
        ux   = xv;
        uy   = yneg ? -yv : yv;
        mx   = (ux > uy) ? ux : uy;
        while (mx >= (64'd1 << 60))
        begin
            mx = mx >> 1;
            ux = ux >> 1;
            uy = uy >> 1;
        end
        while (mx < (64'd1 << 59))
        begin
            mx = mx << 1;
            ux = ux << 1;
            uy = uy << 1;
        end
        cx = longint'(ux);
        cy = yneg ? -longint'(uy) : longint'(uy);
        for (int i = 0; i < STAGES; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy >= 0)
            begin
                cx  = cx + ys;
                cy  = cy - xs;
                acc = acc + longint'(arctan_q60[i]);
            end
            else
            begin
                cx  = cx - ys;
                cy  = cy + xs;
                acc = acc - longint'(arctan_q60[i]);
            end
        end
        return base + acc;
    endfunction

    // Round to the output angle format, halves away from zero.
    function automatic longint round_angle(longint a);
        longint unsigned half;
        half = 64'd1 << (59 - ANGLE_BITS);
        if (a >= 0)
            return longint'(($unsigned(a) + half) >> (60 - ANGLE_BITS));
        return -longint'(($unsigned(-a) + half) >> (60 - ANGLE_BITS));
    endfunction

    function automatic joints_t joint_solution(int x, int y, int z);
        joints_t         j;
        longint          a1;
        longint          a2;
        longint          num;
        longint          den;
        longint          s;
        longint          q1;
        longint          q2;
        longint unsigned rad;
        a1  = link_a1;
        a2  = link_a2;
        num = longint'(x) * x + longint'(y) * y - a1 * a1 - a2 * a2;
        den = 2 * a1 * a2;
        q1  = 0;
        q2  = 0;
        j.reach_fault = (den == 0 || num > den || num < -den);
        if (!j.reach_fault)
        begin
            rad = $unsigned(den * den - num * num) << 20;
            s   = longint'(int_sqrt(rad));
            q2  = round_angle(vector_angle(s, num * 1024));
            q1  = round_angle(vector_angle(y, x))
                - round_angle(vector_angle(a2 * s, a1 * den * 1024 + a2 * num * 1024));
        end
        j.shoulder = q1[19:0];
        j.elbow    = q2[17:0];
        j.travel   = 16'(longint'(z) - longint'(base_z));
        return j;
    endfunction

    task automatic apb_write(reg_idx_t idx, int unsigned value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 4'(idx) << 2;
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_UPPER_ARM:   link_a1 = value & 10'h3FF;
            REG_FOREARM:     link_a2 = value & 10'h3FF;
            REG_BASE_HEIGHT: base_z  = value & 12'hFFF;
            default: ;
        endcase
    endtask

    // Waits until every expected beat has come back and the pipe is empty.
    task automatic drain_pipe();
        while (pending_joints.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    task automatic set_geometry(int unsigned a1, int unsigned a2, int unsigned h);
        drain_pipe();
        apb_write(REG_UPPER_ARM, a1);
        apb_write(REG_FOREARM, a2);
        apb_write(REG_BASE_HEIGHT, h);
    endtask

    // Presents one target from a falling edge until it is taken.
    task automatic send_target(int x, int y, int z);
        start    = 1'b1;
        target_x = 15'(x);
        target_y = 15'(y);
        target_z = 15'(z);
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
            @(negedge clk);
        end
        pending_joints.push_back(joint_solution(x, y, z));
        @(negedge clk);
    endtask

    task automatic idle_gap(int cycles);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Random targets, mostly from a square just wider than the reach of the current arm.
    task automatic random_phase(int count, bit calm);
        int burst;
        int span;
        int x;
        int y;
        burst = 0;
        span  = link_a1 + link_a2 + 2;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if (!calm)
                    idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 7));
            end
            burst--;
            if ($urandom_range(0, 4) == 0)
            begin
                x = $signed(15'($urandom));
                y = $signed(15'($urandom));
            end
            else
            begin
                x = int'($urandom_range(0, 2 * span)) - span;
                y = int'($urandom_range(0, 2 * span)) - span;
            end
            send_target(x, y, $signed(15'($urandom)));
        end
        start = 1'b0;
    endtask

    // Result checker: every done beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        joints_t want;
        joints_t got;
        if (rst_n && done)
        begin
            got = {shoulder_angle, elbow_angle, vertical_travel, out_of_reach};
            if (pending_joints.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = pending_joints.pop_front();
                if (want !== got)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("joint mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving in either direction and no APB access.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("scara_inverse_kinematics test failed");
            $finish;
        end
    end

    initial
    begin
        target_row_t rows [$];
        target_row_t r;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        start      = 1'b0;
        target_x   = '0;
        target_y   = '0;
        target_z   = '0;
        mismatches = 0;
        idle_cycles = 0;
        link_a1    = RST_UPPER_ARM;
        link_a2    = RST_FOREARM;
        base_z     = RST_BASE_HEIGHT;
        arctan_q60[0] = 4 * inverse_arctan(5) - inverse_arctan(239);
        for (int i = 1; i < 32; i++)
            arctan_q60[i] = inverse_arctan(64'd1 << i);

        // Directed targets for the reset geometry; typed rows are out of reach.
        rows = '{
            '{0, 0, 0, 1'b1, '{20'sd0, 18'd0, -16'sd120, 1'b1}},
            '{16383, 16383, 16383, 1'b1, '{20'sd0, 18'd0, 16'sd16263, 1'b1}},
            '{-16384, -16384, -16384, 1'b1, '{20'sd0, 18'd0, -16'sd16504, 1'b1}},
            '{296, 0, 0, 1'b1, '{20'sd0, 18'd0, -16'sd120, 1'b1}},
            '{114, 0, 5, 1'b1, '{20'sd0, 18'd0, -16'sd115, 1'b1}},
            '{295, 0, 0, 1'b0, '0},
            '{0, 295, 16383, 1'b0, '0},
            '{115, 0, -16384, 1'b0, '0},
            '{0, 200, 5, 1'b0, '0},
            '{-200, 0, 120, 1'b0, '0},
            '{-200, -1, 121, 1'b0, '0},
            '{-200, 1, 119, 1'b0, '0},
            '{0, -200, 0, 1'b0, '0},
            '{-150, -150, 7, 1'b0, '0},
            '{100, -100, -1, 1'b0, '0},
            '{-1, 160, 4000, 1'b0, '0},
            '{208, 208, -4000, 1'b0, '0}
        };

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            send_target(r.x, r.y, r.z);
            if (r.typed)
                pending_joints[pending_joints.size() - 1] = r.known;
        end
        idle_gap(0);
        random_phase(PHASE_ITEMS, 1'b0);

        set_geometry(10'd1023, 10'd1023, 12'd4095);
        random_phase(100, 1'b1);
        // Let the pipe empty completely before carrying on.
        drain_pipe();
        random_phase(PHASE_ITEMS - 100, 1'b0);

        set_geometry(10'd1, 10'd1, 12'd0);
        random_phase(PHASE_ITEMS, 1'b0);

        // Zero links: every target is out of reach.
        set_geometry(10'd0, 10'd90, 12'd300);
        random_phase(60, 1'b0);
        set_geometry(10'd300, 10'd0, 12'd4095);
        random_phase(60, 1'b0);

        for (int p = 0; p < 3; p++)
        begin
            set_geometry($urandom_range(1, 1023), $urandom_range(1, 1023),
                         $urandom_range(0, 4095));
            random_phase(PHASE_ITEMS, p[0]);
        end

        set_geometry(RST_UPPER_ARM, RST_FOREARM, RST_BASE_HEIGHT);
        random_phase(PHASE_ITEMS, 1'b0);

        drain_pipe();
        if (mismatches == 0)
            $display("scara_inverse_kinematics test passed");
        else
            $display("scara_inverse_kinematics test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/scara_ik_pkg.sv
hw/rtl/scara_ik_isqrt.sv
hw/rtl/scara_ik_cordic.sv
hw/rtl/scara_inverse_kinematics.sv
tb/tb.sv
